// File: hdl/asb_pkg.sv
// asb_pkg: shared types, constants and fixed-point helpers for the
// additive sine bank. No dependencies; imported by every asb module.
`timescale 1ns / 1ps
package asb_pkg;

  localparam int NUM_OSC_DEFAULT   = 64;
  localparam int SINE_BITS_DEFAULT = 10;

  localparam int PHASE_W     = 32;
  localparam int AMP_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int OSC_IDX_W   = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // polynomial datapath
  localparam int T_W            = 31;
  localparam int P_W            = 34;
  localparam int HORNER_STAGES  = 4;
  localparam logic signed [P_W-1:0] SIN_C9 = 34'sd172272;
  localparam logic signed [P_W-1:0] HORNER_COEF [HORNER_STAGES] = '{
    -34'sd5026995, 34'sd85569306, -34'sd693598668, 34'sd1686629713
  };
  localparam logic signed [P_W+31:0] Q30_RND = (66'sd1 <<< 30) - 66'sd1;

  localparam logic signed [SAMPLE_W-1:0] CLIP_LIMIT = 16'sh7999;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [OSC_IDX_W-1:0]       osc_index;
    logic                       channel_select;
    logic signed [AMP_W-1:0]    amplitude;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } out_item_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic                       is_tick;
    logic                       wr_ok;
    logic [OSC_IDX_W-1:0]       osc;
    logic                       ch;
    logic signed [AMP_W-1:0]    amp;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } eng_state_t;

  // signed Q30 product, truncated toward zero
  function automatic logic signed [P_W-1:0] mul_q30(input logic signed [P_W-1:0] a,
                                                   input logic [T_W-1:0] b);
    logic signed [P_W+31:0] prod;
    prod = a * $signed({1'b0, b});
    if (prod < 0) begin
      prod = prod + Q30_RND;
    end
    return P_W'(prod >>> 30);
  endfunction

endpackage

// File: hdl/asb_front.sv
// asb_front: input side of the synth; takes requests, classifies them and
// queues them for the engine. Depends on asb_pkg.
`timescale 1ns / 1ps
module asb_front #(
  parameter int NUM_OSC = asb_pkg::NUM_OSC_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  asb_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output asb_pkg::cmd_t     cmd
);
  import asb_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              cls;

  assign in_stall  = (count == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = entry[rd_ptr];

  always_comb begin
    cls.is_tick = (in_data.req_type == REQ_TICK);
    cls.wr_ok   = (32'(in_data.osc_index) < 32'(NUM_OSC));
    cls.osc     = in_data.osc_index;
    cls.ch      = in_data.channel_select;
    cls.amp     = in_data.amplitude;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != '0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !cmd_pop |=> count == $past(count) + 1'b1) else $error("push lost");
`endif

endmodule

// File: hdl/asb_sine.sv
// asb_sine: pipelined Q15 sine of a 32-bit phase via an odd Taylor
// polynomial (Horner, one multiply per stage). Depends on asb_pkg.
`timescale 1ns / 1ps
module asb_sine #(
  parameter int SINE_BITS = asb_pkg::SINE_BITS_DEFAULT,
  parameter int SIDE_W    = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [asb_pkg::PHASE_W-1:0]      phase,
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             out_valid,
  output logic signed [asb_pkg::AMP_W-1:0] sine,
  output logic [SIDE_W-1:0]                side_out
);
  import asb_pkg::*;

  localparam int R_W     = SINE_BITS - 2;
  localparam int T_SHIFT = 30 - R_W;
  localparam logic [T_W-1:0] Q30_ONE_U = T_W'(1) << 30;

  logic [SINE_BITS-1:0] k;
  logic [1:0]           q_in;
  logic [T_W-1:0]       t_raw;

  // stage 0: fold into first quadrant
  logic [T_W-1:0]    t0;
  logic [1:0]        q0;
  logic              v0;
  logic [SIDE_W-1:0] sd0;

  // stage 1 .. horner
  logic [T_W-1:0]         t_p   [0:HORNER_STAGES];
  logic [T_W-1:0]         t2_p  [0:HORNER_STAGES];
  logic [1:0]             q_p   [0:HORNER_STAGES];
  logic                   v_p   [0:HORNER_STAGES];
  logic [SIDE_W-1:0]      sd_p  [0:HORNER_STAGES];
  logic signed [P_W-1:0]  p_reg [1:HORNER_STAGES];
  logic [2*T_W-1:0]       tsq;

  logic signed [P_W-1:0] y;
  logic [1:0]            qy;
  logic                  vy;
  logic [SIDE_W-1:0]     sdy;

  logic signed [P_W-1:0] yc;
  logic [18:0]           sv;
  logic [AMP_W-1:0]      smag;

  assign k     = phase[PHASE_W-1 -: SINE_BITS];
  assign q_in  = k[SINE_BITS-1 -: 2];
  assign t_raw = T_W'({k[R_W-1:0], {T_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    t0  <= q_in[0] ? (Q30_ONE_U - t_raw) : t_raw;
    q0  <= q_in;
    sd0 <= side_in;
  end

  assign tsq = t0 * t0;

  always_ff @(posedge clk) begin
    t_p[0]  <= t0;
    t2_p[0] <= tsq[60:30];
    q_p[0]  <= q0;
    sd_p[0] <= sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v_p[0] <= 1'b0;
    end else begin
      v0     <= in_valid;
      v_p[0] <= v0;
    end
  end

  for (genvar j = 0; j < HORNER_STAGES; j++) begin : g_horner
    logic signed [P_W-1:0] p_in;
    if (j == 0) begin : g_first
      assign p_in = SIN_C9;
    end else begin : g_rest
      assign p_in = p_reg[j];
    end
    always_ff @(posedge clk) begin
      p_reg[j+1] <= HORNER_COEF[j] + mul_q30(p_in, t2_p[j]);
      t_p[j+1]   <= t_p[j];
      t2_p[j+1]  <= t2_p[j];
      q_p[j+1]   <= q_p[j];
      sd_p[j+1]  <= sd_p[j];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[j+1] <= 1'b0;
      end else begin
        v_p[j+1] <= v_p[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    y   <= mul_q30(p_reg[HORNER_STAGES], t_p[HORNER_STAGES]);
    qy  <= q_p[HORNER_STAGES];
    sdy <= sd_p[HORNER_STAGES];
  end

  // round Q30 to Q15, saturate, apply sign of lower half-turn
  always_comb begin
    yc   = (y < 0) ? '0 : y;
    sv   = 19'((yc + 34'sd16384) >>> 15);
    smag = (sv > 19'd32767) ? 16'd32767 : sv[AMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    sine     <= qy[1] ? -$signed(smag) : $signed(smag);
    side_out <= sdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vy        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vy        <= v_p[HORNER_STAGES];
      out_valid <= vy;
    end
  end

endmodule

// File: hdl/asb_engine.sv
// asb_engine: back end; holds phase and amplitude memories, sweeps the
// oscillators through the sine pipeline, mixes and clips. Uses asb_pkg, asb_sine.
`timescale 1ns / 1ps
module asb_engine #(
  parameter int NUM_OSC   = asb_pkg::NUM_OSC_DEFAULT,
  parameter int SINE_BITS = asb_pkg::SINE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  asb_pkg::cmd_t                 cmd,
  input  logic [asb_pkg::PHASE_W-1:0]   base_increment,
  input  logic [asb_pkg::PHASE_W-1:0]   increment_spacing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output asb_pkg::out_item_t            out_data
);
  import asb_pkg::*;

  localparam int OSC_W  = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int ACC_W  = 2 * AMP_W + OSC_W + 1;
  localparam int NUM_W  = ACC_W + 2;
  localparam int SIDE_W = 2 * AMP_W + 1;
  localparam logic [OSC_W-1:0] LAST_OSC = OSC_W'(NUM_OSC - 1);
  localparam logic signed [NUM_W-1:0] LIM = NUM_W'(32'h7999) <<< 16;

  eng_state_t state, state_next;

  logic [PHASE_W-1:0]       phase_mem [NUM_OSC];
  logic signed [AMP_W-1:0]  ampl_mem  [NUM_OSC];
  logic signed [AMP_W-1:0]  ampr_mem  [NUM_OSC];

  logic [OSC_W-1:0]         cnt;
  logic [OSC_W-1:0]         rd_idx;
  logic                     rd_valid;
  logic                     rd_last;
  logic [PHASE_W-1:0]       phase_rd;
  logic signed [AMP_W-1:0]  ampl_rd;
  logic signed [AMP_W-1:0]  ampr_rd;
  logic [PHASE_W-1:0]       step_acc;

  logic                     ph_we;
  logic [OSC_W-1:0]         ph_wa;
  logic [PHASE_W-1:0]       ph_wd;
  logic                     al_we;
  logic                     ar_we;
  logic [OSC_W-1:0]         amp_wa;
  logic signed [AMP_W-1:0]  amp_wd;

  logic                     s_valid;
  logic signed [AMP_W-1:0]  s_val;
  logic [SIDE_W-1:0]        s_side;
  logic signed [2*AMP_W-1:0] prod_l;
  logic signed [2*AMP_W-1:0] prod_r;
  logic                     prod_vld;
  logic                     prod_last;
  logic signed [ACC_W-1:0]  acc_l;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [NUM_W-1:0]  num_l;
  logic signed [NUM_W-1:0]  num_r;
  logic                     start_tick;
  logic                     emit;
  logic                     sweep_last;

  function automatic logic signed [SAMPLE_W-1:0] clip(input logic signed [NUM_W-1:0] n);
    logic signed [NUM_W-1:0] adj;
    adj = (n < 0) ? n + NUM_W'(17'h0FFFF) : n;
    if (n >= LIM) begin
      return CLIP_LIMIT;
    end else if (n <= -LIM) begin
      return -CLIP_LIMIT;
    end
    return SAMPLE_W'(adj >>> 16);
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[ph_wa] <= ph_wd;
    end
    phase_rd <= phase_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      ampl_mem[amp_wa] <= amp_wd;
    end
    ampl_rd <= ampl_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (ar_we) begin
      ampr_mem[amp_wa] <= amp_wd;
    end
    ampr_rd <= ampr_mem[cnt];
  end

  assign sweep_last = (state == ST_SWEEP) && (cnt == LAST_OSC);
  assign emit       = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    start_tick = 1'b0;
    al_we      = 1'b0;
    ar_we      = 1'b0;
    amp_wa     = OSC_W'(cmd.osc);
    amp_wd     = cmd.amp;
    ph_we      = rd_valid;
    ph_wa      = rd_idx;
    ph_wd      = phase_rd + step_acc;
    unique case (state)
      ST_CLEAR: begin
        ph_we  = 1'b1;
        ph_wa  = cnt;
        ph_wd  = '0;
        al_we  = 1'b1;
        ar_we  = 1'b1;
        amp_wa = cnt;
        amp_wd = '0;
        if (cnt == LAST_OSC) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_tick) begin
            start_tick = 1'b1;
            state_next = ST_SWEEP;
          end else if (cmd.wr_ok) begin
            al_we = !cmd.ch;
            ar_we = cmd.ch;
          end
        end
      end
      ST_SWEEP: begin
        if (cnt == LAST_OSC) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_vld && prod_last) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SWEEP);
      if (state == ST_CLEAR || state == ST_SWEEP) begin
        cnt <= (cnt == LAST_OSC) ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= cnt;
    rd_last <= sweep_last;
    if (start_tick) begin
      step_acc <= base_increment;
    end else if (rd_valid) begin
      step_acc <= step_acc + increment_spacing;
    end
  end

  asb_sine #(
    .SINE_BITS (SINE_BITS),
    .SIDE_W    (SIDE_W)
  ) u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .phase     (phase_rd),
    .side_in   ({rd_last, ampl_rd, ampr_rd}),
    .out_valid (s_valid),
    .sine      (s_val),
    .side_out  (s_side)
  );

  always_ff @(posedge clk) begin
    prod_l    <= s_val * $signed(s_side[2*AMP_W-1:AMP_W]);
    prod_r    <= s_val * $signed(s_side[AMP_W-1:0]);
    prod_last <= s_side[SIDE_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start_tick) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (prod_vld) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state == ST_SCALE) begin
      num_l <= (NUM_W'(acc_l) <<< 1) + NUM_W'(acc_l);
      num_r <= (NUM_W'(acc_r) <<< 1) + NUM_W'(acc_r);
    end
  end

  // result register frees the engine from the output side
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.left_sample  <= clip(num_l);
      out_data.right_sample <= clip(num_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE) else $error("request taken while busy");
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.left_sample <= CLIP_LIMIT && out_data.left_sample >= -CLIP_LIMIT
                && out_data.right_sample <= CLIP_LIMIT
                && out_data.right_sample >= -CLIP_LIMIT)) else $error("sample out of range");
  a_sweep_flow: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |=> (state == ST_SWEEP || state == ST_DRAIN)) else $error("sweep broken");
`endif

endmodule

// File: hdl/additive_sine_bank_synth_core.sv
// additive_sine_bank_synth_core: top level of the additive sine bank.
// Holds the config registers and joins asb_front and asb_engine; uses asb_pkg.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  in_data (in_item_t)
//   out_*        out   out_valid/out_stall out_data (out_item_t)
//   cfg_*        in    cfg_we             cfg_index, cfg_data
//
// an amplitude write is done as the engine pops it in its idle state; a tick
// sweeps the oscillators through the sine pipeline, one oscillator per cycle.
// after reset the engine clears its memories while requests queue up. a
// two-entry queue takes requests while the engine works, and a waiting
// result only holds the engine at its final step.
`timescale 1ns / 1ps
module additive_sine_bank_synth_core #(
  parameter int NUM_OSC   = asb_pkg::NUM_OSC_DEFAULT,
  parameter int SINE_BITS = asb_pkg::SINE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  asb_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output asb_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [asb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asb_pkg::PHASE_W-1:0]   cfg_data
);
  import asb_pkg::*;

  logic [PHASE_W-1:0] base_increment;
  logic [PHASE_W-1:0] increment_spacing;
  logic               cmd_valid;
  logic               cmd_pop;
  cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment    <= '0;
      increment_spacing <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_INC) begin
        base_increment <= cfg_data;
      end else if (cfg_index == CFG_SPACING) begin
        increment_spacing <= cfg_data;
      end
    end
  end

  asb_front #(
    .NUM_OSC (NUM_OSC)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  asb_engine #(
    .NUM_OSC   (NUM_OSC),
    .SINE_BITS (SINE_BITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop),
    .cmd               (cmd),
    .base_increment    (base_increment),
    .increment_spacing (increment_spacing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data)
  );

endmodule

// File: verif/additive_sine_bank_synth_core_test.sv
// additive_sine_bank_synth_core_test: self-checking bench for the additive sine bank.
// Drives amplitude writes and ticks, predicts each stereo frame; uses asb_pkg.
`timescale 1ns / 1ps
module additive_sine_bank_synth_core_test;
  import asb_pkg::*;

  localparam int NOSC = 64;
  localparam int SBITS = 10;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_INC;
  logic [PHASE_W-1:0] cfg_data = '0;

  additive_sine_bank_synth_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // bench copy of the bank state
  logic [31:0] base_inc_m, spacing_m;
  logic [31:0] phase_m [NOSC];
  logic signed [15:0] amp_m [2*NOSC];

  in_item_t request_q [$];
  out_item_t frame_q [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  longint cycles = 0;

  function automatic longint sine_q15(input logic [31:0] ph);
    longint k, q, r, t, t2, p, y, s;
    k = ph >> (32 - SBITS);
    q = (k >> (SBITS - 2)) & 3;
    r = k & ((1 << (SBITS - 2)) - 1);
    t = r * (64'sd1 << (30 - (SBITS - 2)));
    if (q & 1) t = Q30 - t;
    t2 = (t * t) / Q30;
    p = 172272;
    p = -5026995 + (p * t2) / Q30;
    p = 85569306 + (p * t2) / Q30;
    p = -693598668 + (p * t2) / Q30;
    p = 1686629713 + (p * t2) / Q30;
    y = (p * t) / Q30;
    if (y < 0) y = 0;
    s = (y + 16384) / 32768;
    if (s > 32767) s = 32767;
    return (q >= 2) ? -s : s;
  endfunction

  function automatic logic [15:0] clip_channel(input longint acc);
    longint num, lim;
    num = acc * 3;
    lim = longint'(CLIP_LIMIT) * 65536;
    if (num >= lim) return CLIP_LIMIT;
    if (num <= -lim) return -CLIP_LIMIT;
    return 16'(num / 65536);
  endfunction

  task automatic predict_frame(input in_item_t req);
    longint accl, accr, s;
    out_item_t f;
    accl = 0;
    accr = 0;
    if (req.req_type == REQ_WRITE) begin
      amp_m[2*req.osc_index + req.channel_select] = req.amplitude;
    end else begin
      for (int i = 0; i < NOSC; i++) begin
        s = sine_q15(phase_m[i]);
        accl += s * amp_m[2*i];
        accr += s * amp_m[2*i+1];
      end
      for (int i = 0; i < NOSC; i++) begin
        phase_m[i] = phase_m[i] + base_inc_m + 32'(i) * spacing_m;
      end
      f.left_sample = clip_channel(accl);
      f.right_sample = clip_channel(accr);
      frame_q.push_back(f);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_frame(in_data);
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame %h", out_data);
      end else begin
        out_item_t e;
        e = frame_q.pop_front();
        if (e.left_sample !== out_data.left_sample ||
            e.right_sample !== out_data.right_sample) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                     e.left_sample, e.right_sample,
                     out_data.left_sample, out_data.right_sample);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_item_t rand_write(input bit full_range);
    in_item_t r;
    r.req_type = REQ_WRITE;
    r.osc_index = OSC_IDX_W'($urandom_range(NOSC-1));
    r.channel_select = 1'($urandom_range(1));
    r.amplitude = full_range ? 16'($urandom) : 16'($signed($urandom_range(2047)) - 1024);
    return r;
  endfunction

  function automatic in_item_t tick_req();
    in_item_t r;
    r = in_item_t'($bits(in_item_t)'($urandom));
    r.req_type = REQ_TICK;
    return r;
  endfunction

  task automatic wait_drained();
    while (request_q.size() > 0 || in_valid || frame_q.size() > 0) @(posedge clk);
    repeat (NOSC + 40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_INC) base_inc_m = v;
    else spacing_m = v;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: request_q.push_back(tick_req());
        4: request_q.push_back(rand_write(1'b1));
        default: request_q.push_back(rand_write($urandom_range(3) == 0));
      endcase
    end
    wait_drained();
  endtask

  initial begin
    in_item_t r;
    logic [31:0] bases [4];
    logic [31:0] spcs [4];
    bases = '{32'h0, 32'hFFFF_FFFF, 32'h0123_4567, 32'h0040_0000};
    spcs = '{32'h0, 32'hFFFF_FFFF, 32'h0010_0000, 32'h89AB_CDEF};
    base_inc_m = '0;
    spacing_m = '0;
    for (int i = 0; i < NOSC; i++) phase_m[i] = '0;
    for (int i = 0; i < 2*NOSC; i++) amp_m[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first frame at phase zero, extreme amplitudes, clipping both ways
    write_reg(CFG_BASE_INC, 32'h0200_0000);
    write_reg(CFG_SPACING, 32'h0100_0000);
    request_q.push_back(tick_req());
    for (int i = 0; i < 8; i++) begin
      r = '0;
      r.req_type = REQ_WRITE;
      r.osc_index = (i == 0) ? 6'd63 : 6'(i);
      r.channel_select = i[0];
      r.amplitude = i[1] ? 16'sh8000 : 16'sh7FFF;
      request_q.push_back(r);
    end
    r = '0;
    r.osc_index = 6'd63;
    r.channel_select = 1'b1;
    r.amplitude = 16'sh8000;
    request_q.push_back(r);
    for (int i = 0; i < 10; i++) request_q.push_back(tick_req());
    wait_drained();

    // long output hold-off so the block backs up
    for (int i = 0; i < 12; i++) request_q.push_back(tick_req());
    hold_cycles = 2000;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BASE_INC, (p < 4) ? bases[p] : $urandom);
      write_reg(CFG_SPACING, (p < 4) ? spcs[p] : $urandom);
      case (p % 4)
        0: run_phase(225, 0, 0);
        1: run_phase(225, 77, 0);
        2: run_phase(225, 0, 77);
        default: run_phase(225, 31, 31);
      endcase
    end

    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/asb_pkg.sv
hdl/asb_front.sv
hdl/asb_sine.sv
hdl/asb_engine.sv
hdl/additive_sine_bank_synth_core.sv
verif/additive_sine_bank_synth_core_test.sv
